>>> design/uvc_pkg.sv
// Shared types and constants of the UV arc event classifier.
`default_nettype none
package uvc_pkg;

  localparam int unsigned LevelBits = 12;
  localparam int unsigned DeltaBits = 13;
  localparam int unsigned CountBits = 16;
  localparam int unsigned LimitBits = 7;
  localparam int unsigned CfgIndexBits = 4;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [LimitBits-1:0] PercentScale = 7'd100;

  // Register indexes of the configuration port
  localparam logic [CfgIndexBits-1:0] RegAmpThreshold     = 4'd0;
  localparam logic [CfgIndexBits-1:0] RegRateThresholdMax = 4'd1;
  localparam logic [CfgIndexBits-1:0] RegRateThresholdImp = 4'd2;
  localparam logic [CfgIndexBits-1:0] RegRateThresholdMin = 4'd3;
  localparam logic [CfgIndexBits-1:0] RegMinObservations  = 4'd4;
  localparam logic [CfgIndexBits-1:0] RegProbLimitHigh    = 4'd5;
  localparam logic [CfgIndexBits-1:0] RegProbLimitLow     = 4'd6;
  localparam logic [CfgIndexBits-1:0] RegSamplesPerPeriod = 4'd7;

  typedef enum logic [2:0] {
    CLS_IDLE = 3'd0,
    CLS_AMP  = 3'd1,
    CLS_IMP  = 3'd2,
    CLS_RISE = 3'd3,
    CLS_HOT  = 3'd4
  } class_t;

  typedef struct packed {
    logic [LevelBits-1:0] amp_threshold;
    logic [LevelBits-1:0] rate_threshold_max;
    logic [LevelBits-1:0] rate_threshold_impulse;
    logic [LevelBits-1:0] rate_threshold_min;
    logic [CountBits-1:0] min_observations;
    logic [LimitBits-1:0] prob_limit_high;
    logic [LimitBits-1:0] prob_limit_low;
    logic [CountBits-1:0] period_len;
  } cfg_t;

  // Item handed from the front end to the classifier
  typedef struct packed {
    logic [LevelBits-1:0]        level;
    logic signed [DeltaBits-1:0] delta;
    logic                        f_imp;
    logic                        f_rate;
    logic                        f_amp;
  } front_item_t;

  typedef struct packed {
    class_t cls;
    logic   f_imp;
    logic   f_rate;
    logic   f_amp;
    logic   entered_hot;
  } result_t;

endpackage
`default_nettype wire

>>> design/uvc_fifo.sv
// Two-entry item queue with registered storage.
`default_nettype none
module uvc_fifo
  import uvc_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  input  logic             pop,
  output logic [Width-1:0] head_data,
  output logic             full,
  output logic             empty
);

  logic [Width-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage carries payload only
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

>>> design/uvc_front.sv
// Front end: masks the sample, forms the difference and raises the flags.
`default_nettype none
module uvc_front
  import uvc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [LevelBits-1:0] adc_sample,
  input  cfg_t                 cfg,
  output front_item_t          item
);

  localparam logic [LevelBits-1:0] LevelMask =
    (SAMPLE_BITS >= LevelBits) ? {LevelBits{1'b1}} :
    LevelBits'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [LevelBits-1:0]        last_level;
  logic [LevelBits-1:0]        level;
  logic signed [DeltaBits-1:0] delta;
  logic                        f_imp;

  assign level = adc_sample & LevelMask;
  assign delta = $signed({1'b0, level}) - $signed({1'b0, last_level});
  assign f_imp = delta > $signed({1'b0, cfg.rate_threshold_impulse});

  always_comb begin
    item.level  = level;
    item.delta  = delta;
    item.f_imp  = f_imp;
    item.f_rate = !f_imp && (delta > $signed({1'b0, cfg.rate_threshold_max}));
    item.f_amp  = level > cfg.amp_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
    end else if (accept) begin
      last_level <= level;
    end
  end

endmodule
`default_nettype wire

>>> design/uvc_back.sv
// Back end: five-state classifier with observation counters and decision.
`default_nettype none
module uvc_back
  import uvc_pkg::*;
#(
  parameter int unsigned NOISE_MARGIN = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  front_item_t item,
  input  cfg_t        cfg,
  output result_t     result
);

  localparam logic signed [DeltaBits:0] Margin = (DeltaBits+1)'(NOISE_MARGIN);
  localparam int unsigned ProdBits = CountBits + LimitBits;

  class_t                      cls;
  class_t                      cls_next;
  logic [CountBits-1:0]        obs_count;
  logic [CountBits-1:0]        obs_count_next;
  logic [CountBits-1:0]        pos_count;
  logic [CountBits-1:0]        pos_count_next;
  logic [LevelBits-1:0]        start_level;
  logic [LevelBits-1:0]        start_level_next;
  logic signed [DeltaBits-1:0] last_delta;

  logic [CountBits-1:0]        obs_inc;
  logic [CountBits-1:0]        obs_mid;
  logic [CountBits-1:0]        pos_mid;
  logic                        pos_bump;
  logic [ProdBits-1:0]         pos_prod;
  logic [ProdBits-1:0]         high_prod;
  logic [ProdBits-1:0]         low_prod;
  logic                        dec_high;
  logic                        dec_low;
  logic signed [DeltaBits:0]   rise;
  logic                        early_pos;

  assign obs_inc = (obs_count == CountMax) ? obs_count : obs_count + 1'b1;

  // Exact percentage compare on the counts after this item's update
  assign pos_prod  = ProdBits'(pos_mid) * ProdBits'(PercentScale);
  assign high_prod = ProdBits'(obs_mid) * ProdBits'(cfg.prob_limit_high);
  assign low_prod  = ProdBits'(obs_mid) * ProdBits'(cfg.prob_limit_low);
  assign dec_high  = pos_prod > high_prod;
  assign dec_low   = pos_prod < low_prod;

  assign rise = $signed({2'b00, item.level}) - $signed({2'b00, start_level});
  assign early_pos = (item.delta > $signed({1'b0, cfg.rate_threshold_min})) &&
                     (obs_inc < CountBits'(cfg.period_len[CountBits-1:3]));

  always_comb begin
    pos_bump = 1'b0;
    obs_mid  = obs_inc;
    case (cls)
      CLS_AMP:  pos_bump = item.f_amp;
      CLS_IMP:  pos_bump = item.f_amp || item.f_rate || early_pos;
      CLS_RISE: pos_bump = item.f_rate || item.f_amp;
      CLS_HOT:  pos_bump = item.f_amp;
      default:  obs_mid  = obs_count;
    endcase
    pos_mid = (pos_bump && pos_count != CountMax) ? pos_count + 1'b1 : pos_count;
  end

  always_comb begin
    cls_next         = cls;
    obs_count_next   = obs_mid;
    pos_count_next   = pos_mid;
    start_level_next = start_level;
    case (cls)
      CLS_IDLE: begin
        if (item.f_imp || item.f_rate || item.f_amp) begin
          obs_count_next   = CountBits'(1);
          pos_count_next   = CountBits'(1);
          start_level_next = item.level;
          if (item.f_amp) cls_next = CLS_AMP;
          else if (item.f_imp) cls_next = CLS_IMP;
          else if (!last_delta[DeltaBits-1]) cls_next = CLS_RISE;
        end
      end
      CLS_AMP: begin
        if (obs_mid > cfg.min_observations) begin
          if (dec_high) begin
            cls_next       = CLS_HOT;
            pos_count_next = '0;
          end else if (dec_low) begin
            cls_next = CLS_IDLE;
          end
        end
      end
      CLS_IMP, CLS_RISE: begin
        if (item.f_amp && !(cls == CLS_RISE && item.f_rate)) cls_next = CLS_AMP;
        else if (cls == CLS_IMP && item.f_rate) cls_next = CLS_RISE;
        // Probability decision may override the move above
        if (obs_mid >= cfg.min_observations) begin
          if (dec_high) begin
            if (rise > Margin) begin
              cls_next       = CLS_HOT;
              pos_count_next = '0;
            end
          end else if (dec_low) begin
            cls_next = CLS_IDLE;
          end
        end
      end
      CLS_HOT: begin
        if (obs_mid > cfg.period_len) begin
          if (pos_mid == '0) cls_next = CLS_IDLE;
          obs_count_next = '0;
          pos_count_next = '0;
        end
      end
      default: cls_next = CLS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls         <= CLS_IDLE;
      obs_count   <= '0;
      pos_count   <= '0;
      start_level <= '0;
      last_delta  <= '0;
    end else if (take) begin
      cls         <= cls_next;
      obs_count   <= obs_count_next;
      pos_count   <= pos_count_next;
      start_level <= start_level_next;
      last_delta  <= item.delta;
    end
  end

  always_comb begin
    result.cls         = cls_next;
    result.f_imp       = item.f_imp;
    result.f_rate      = item.f_rate;
    result.f_amp       = item.f_amp;
    result.entered_hot = (cls_next == CLS_HOT) && (cls != CLS_HOT);
  end

endmodule
`default_nettype wire

>>> design/uv_arc_event_classifier.sv
// Top level of the UV arc event classifier: config registers, front end, queues, classifier.
`default_nettype none
// One converter sample goes in per item and exactly one result comes out, in order.
// The front end masks the sample, forms its difference from the previous one and
// raises the impulse, fast-rise and amplitude flags; it hands the item through a
// two-entry queue to the classifier, which runs the five-state machine (idle,
// amplitude, impulse, rising, hot), the saturating observation and positive counters
// and the exact percentage decision (100*pos against limit*obs). Results wait in a
// second two-entry queue. The block sustains one item per clock cycle with push and
// pop both held high; an accepted item passes through the input queue and the
// classifier into the result queue, whose head drives the result ports.
// The classifier's state update sets that rate. Full rises only when
// the input queue holds two items, so a stalled consumer backs up into push/full.
// Configuration writes are registered and must be made with no item in flight.
module uv_arc_event_classifier
  import uvc_pkg::*;
#(
  parameter int unsigned NOISE_MARGIN = 16,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  // input queue side
  input  logic                    push,
  output logic                    full,
  input  logic [LevelBits-1:0]    adc_sample,
  // result queue side
  input  logic                    pop,
  output logic                    empty,
  output logic [2:0]              class_state,
  output logic                    flag_impulse,
  output logic                    flag_rate,
  output logic                    flag_amplitude,
  output logic                    entered_hot,
  // configuration write port
  input  logic                    cfg_wr_en,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data
);

  cfg_t        cfg;
  front_item_t front_item;
  front_item_t back_item;
  result_t     back_result;
  result_t     head_result;
  logic        in_accept;
  logic        mid_empty;
  logic        out_full;
  logic        back_take;

  // Configuration registers: keep only each register's width, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_threshold          <= 12'd4095;
      cfg.rate_threshold_max     <= 12'd4095;
      cfg.rate_threshold_impulse <= 12'd4095;
      cfg.rate_threshold_min     <= 12'd0;
      cfg.min_observations       <= 16'd16;
      cfg.prob_limit_high        <= 7'd80;
      cfg.prob_limit_low         <= 7'd20;
      cfg.period_len             <= 16'd200;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegAmpThreshold:     cfg.amp_threshold          <= cfg_data[LevelBits-1:0];
        RegRateThresholdMax: cfg.rate_threshold_max     <= cfg_data[LevelBits-1:0];
        RegRateThresholdImp: cfg.rate_threshold_impulse <= cfg_data[LevelBits-1:0];
        RegRateThresholdMin: cfg.rate_threshold_min     <= cfg_data[LevelBits-1:0];
        RegMinObservations:  cfg.min_observations       <= cfg_data[CountBits-1:0];
        RegProbLimitHigh:    cfg.prob_limit_high        <= cfg_data[LimitBits-1:0];
        RegProbLimitLow:     cfg.prob_limit_low         <= cfg_data[LimitBits-1:0];
        RegSamplesPerPeriod: cfg.period_len             <= cfg_data[CountBits-1:0];
        default:             cfg                        <= cfg;
      endcase
    end
  end

  assign in_accept = push && !full;

  uvc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .adc_sample(adc_sample),
    .cfg       (cfg),
    .item      (front_item)
  );

  // Input-side queue: decouple the front end from the classifier
  uvc_fifo #(
    .Width($bits(front_item_t))
  ) u_mid_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_item),
    .pop      (back_take),
    .head_data(back_item),
    .full     (full),
    .empty    (mid_empty)
  );

  // Advance the classifier whenever an item waits and the result queue has room
  assign back_take = !mid_empty && !out_full;

  uvc_back #(
    .NOISE_MARGIN(NOISE_MARGIN)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .take  (back_take),
    .item  (back_item),
    .cfg   (cfg),
    .result(back_result)
  );

  // Result queue: hold finished items until popped
  uvc_fifo #(
    .Width($bits(result_t))
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (back_take),
    .push_data(back_result),
    .pop      (pop),
    .head_data(head_result),
    .full     (out_full),
    .empty    (empty)
  );

  assign class_state    = head_result.cls;
  assign flag_impulse   = head_result.f_imp;
  assign flag_rate      = head_result.f_rate;
  assign flag_amplitude = head_result.f_amp;
  assign entered_hot    = head_result.entered_hot;

`ifndef SYNTH
  // A result that enters hot must report the hot state
  a_entered_hot_state: assert property (@(posedge clk) disable iff (rst)
    (!empty && entered_hot) |-> (class_state == CLS_HOT))
    else $error("entered_hot without hot state");

  // Impulse and fast-rise flags are exclusive
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(flag_impulse && flag_rate))
    else $error("impulse and rate flags both set");

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the UV arc event classifier: directed, random and hot-hold runs.
module tb_top;
  import uvc_pkg::*;

  localparam int NoiseMargin = 16;
  localparam int MaxLevel = (1 << LevelBits) - 1;
  localparam int HotHoldItems = 150;
  // Indexes past the last register; writes there must change nothing
  localparam logic [CfgIndexBits-1:0] RegFirstUnused = 4'd8;
  localparam logic [CfgIndexBits-1:0] RegLastUnused  = 4'd15;

  // Waveform shapes of the random traffic; the first four are sensor-like
  typedef enum int {
    SHAPE_QUIET,
    SHAPE_RAMP,
    SHAPE_IMPULSE,
    SHAPE_PLATEAU,
    SHAPE_NOISE,
    SHAPE_EXTREME
  } shape_t;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    push       = 1'b0;
  logic [LevelBits-1:0]    adc_sample = '0;
  logic                    pop        = 1'b0;
  logic                    cfg_wr_en  = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index  = '0;
  logic [CfgDataBits-1:0]  cfg_data   = '0;
  logic                    full;
  logic                    empty;
  logic [2:0]              class_state;
  logic                    flag_impulse;
  logic                    flag_rate;
  logic                    flag_amplitude;
  logic                    entered_hot;

  // Percentage of cycles in which each side holds off
  int unsigned send_idle_pct = 12;
  int unsigned take_idle_pct = 77;

  int      mismatch_count = 0;
  result_t pending_results[$];

  // Predictor state, kept at the widths of the block
  class_t                      cls_q;
  logic [LevelBits-1:0]        prev_level;
  logic signed [DeltaBits-1:0] prev_delta;
  logic [CountBits-1:0]        obs_q;
  logic [CountBits-1:0]        pos_q;
  logic [LevelBits-1:0]        start_level_q;

  // Predictor copy of the configuration registers
  logic [LevelBits-1:0] amp_thr;
  logic [LevelBits-1:0] rate_max;
  logic [LevelBits-1:0] rate_imp;
  logic [LevelBits-1:0] rate_min;
  logic [CountBits-1:0] min_obs;
  logic [LimitBits-1:0] lim_high;
  logic [LimitBits-1:0] lim_low;
  logic [CountBits-1:0] spp;

  always #2 clk = ~clk;

  uv_arc_event_classifier #(
    .NOISE_MARGIN(NoiseMargin),
    .SAMPLE_BITS (LevelBits)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .adc_sample    (adc_sample),
    .pop           (pop),
    .empty         (empty),
    .class_state   (class_state),
    .flag_impulse  (flag_impulse),
    .flag_rate     (flag_rate),
    .flag_amplitude(flag_amplitude),
    .entered_hot   (entered_hot),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    amp_thr       = 12'd4095;
    rate_max      = 12'd4095;
    rate_imp      = 12'd4095;
    rate_min      = '0;
    min_obs       = 16'd16;
    lim_high      = 7'd80;
    lim_low       = 7'd20;
    spp           = 16'd200;
    cls_q         = CLS_IDLE;
    prev_level    = '0;
    prev_delta    = '0;
    obs_q         = '0;
    pos_q         = '0;
    start_level_q = '0;
  endfunction

  // Keep only the width of the addressed register; drop unknown indexes
  function automatic void apply_register(logic [CfgIndexBits-1:0] idx,
                                         logic [CfgDataBits-1:0] data);
    case (idx)
      RegAmpThreshold:     amp_thr  = data[LevelBits-1:0];
      RegRateThresholdMax: rate_max = data[LevelBits-1:0];
      RegRateThresholdImp: rate_imp = data[LevelBits-1:0];
      RegRateThresholdMin: rate_min = data[LevelBits-1:0];
      RegMinObservations:  min_obs  = data[CountBits-1:0];
      RegProbLimitHigh:    lim_high = data[LimitBits-1:0];
      RegProbLimitLow:     lim_low  = data[LimitBits-1:0];
      RegSamplesPerPeriod: spp      = data[CountBits-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Exact share compare, no division: +1 above the high limit, -1 below the low one
  function automatic int share_verdict();
    int unsigned share;
    int unsigned hi_bound;
    int unsigned lo_bound;
    share    = 100 * pos_q;
    hi_bound = lim_high * obs_q;
    lo_bound = lim_low * obs_q;
    if (share > hi_bound) return 1;
    if (share < lo_bound) return -1;
    return 0;
  endfunction

  // Decision of the impulse and rising states: hot also needs a real rise in level
  function automatic void decide_with_rise(logic [LevelBits-1:0] level);
    int verdict;
    if (obs_q < min_obs) return;
    verdict = share_verdict();
    if (verdict > 0) begin
      if (int'(level) - int'(start_level_q) > NoiseMargin) begin
        cls_q = CLS_HOT;
        pos_q = '0;
      end
    end else if (verdict < 0) begin
      cls_q = CLS_IDLE;
    end
  endfunction

  function automatic result_t classify_sample(logic [LevelBits-1:0] level);
    result_t res;
    int      delta;
    int      verdict;
    logic    f_imp;
    logic    f_rate;
    logic    f_amp;
    class_t  was;
    delta  = int'(level) - int'(prev_level);
    f_imp  = delta > int'(rate_imp);
    f_rate = !f_imp && (delta > int'(rate_max));
    f_amp  = level > amp_thr;
    was    = cls_q;
    case (cls_q)
      CLS_IDLE: begin
        if (f_imp || f_rate || f_amp) begin
          // Counters and start level load even when a blocked rise stays idle
          obs_q         = 16'd1;
          pos_q         = 16'd1;
          start_level_q = level;
          if (f_amp) cls_q = CLS_AMP;
          else if (f_imp) cls_q = CLS_IMP;
          else if (prev_delta >= 0) cls_q = CLS_RISE;
        end
      end
      CLS_AMP: begin
        obs_q = sat_inc(obs_q);
        if (f_amp) pos_q = sat_inc(pos_q);
        if (obs_q > min_obs) begin
          verdict = share_verdict();
          if (verdict > 0) begin
            cls_q = CLS_HOT;
            pos_q = '0;
          end else if (verdict < 0) begin
            cls_q = CLS_IDLE;
          end
        end
      end
      CLS_IMP: begin
        obs_q = sat_inc(obs_q);
        if (f_amp) begin
          pos_q = sat_inc(pos_q);
          cls_q = CLS_AMP;
        end else if (f_rate) begin
          pos_q = sat_inc(pos_q);
          cls_q = CLS_RISE;
        end else if (delta > int'(rate_min) && obs_q < (spp >> 3)) begin
          pos_q = sat_inc(pos_q);
        end
        decide_with_rise(level);
      end
      CLS_RISE: begin
        obs_q = sat_inc(obs_q);
        if (f_rate) begin
          pos_q = sat_inc(pos_q);
        end else if (f_amp) begin
          pos_q = sat_inc(pos_q);
          cls_q = CLS_AMP;
        end
        decide_with_rise(level);
      end
      default: begin
        // Hot: expire after a whole period without positives
        obs_q = sat_inc(obs_q);
        if (f_amp) pos_q = sat_inc(pos_q);
        if (obs_q > spp) begin
          if (pos_q == '0) cls_q = CLS_IDLE;
          obs_q = '0;
          pos_q = '0;
        end
      end
    endcase
    prev_level      = level;
    prev_delta      = delta[DeltaBits-1:0];
    res.cls         = cls_q;
    res.f_imp       = f_imp;
    res.f_rate      = f_rate;
    res.f_amp       = f_amp;
    res.entered_hot = (cls_q == CLS_HOT) && (was != CLS_HOT);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item from a falling edge and hold it until the block takes it
  task automatic send_sample(logic [LevelBits-1:0] sample);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk); while (full);
    pending_results.push_back(classify_sample(sample));
  endtask

  // Drop push, drain every pending result and give the pipeline time to empty
  task automatic settle_block();
    if (push) begin
      @(negedge clk);
      push <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] data);
    settle_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Fill the bits above the register's width with noise; the block must drop them
  function automatic logic [CfgDataBits-1:0] with_junk(int unsigned value, int width);
    return (CfgDataBits'($urandom) << width) | CfgDataBits'(value);
  endfunction

  // Mostly a working value, now and then one of the two extremes
  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned floor_val, int unsigned ceil_val);
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return floor_val;
    if (roll == 1) return ceil_val;
    return $urandom_range(lo, hi);
  endfunction

  // Receiver: hold off pop at random, decided at each falling edge
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= take_idle_pct);
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", class_state, 0);
      end else begin
        want = pending_results.pop_front();
        if (class_state !== want.cls) report_mismatch("class_state", class_state, want.cls);
        if (flag_impulse !== want.f_imp)
          report_mismatch("flag_impulse", flag_impulse, want.f_imp);
        if (flag_rate !== want.f_rate) report_mismatch("flag_rate", flag_rate, want.f_rate);
        if (flag_amplitude !== want.f_amp)
          report_mismatch("flag_amplitude", flag_amplitude, want.f_amp);
        if (entered_hot !== want.entered_hot)
          report_mismatch("entered_hot", entered_hot, want.entered_hot);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds sit at full scale, so even extreme samples raise no flag
  task automatic test_reset_thresholds();
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
  endtask

  // Amplitude run that goes hot on share, then expires after a short period
  task automatic test_amplitude_to_hot();
    write_reg(RegAmpThreshold, 16'd1000);
    write_reg(RegMinObservations, 16'd3);
    write_reg(RegSamplesPerPeriod, 16'd4);
    repeat (4) send_sample(12'd2000);
    send_sample(12'd0);
  endtask

  // Jump then a small early rise: hot via the impulse state with the rise margin met;
  // a zero period then drops hot on the very next item
  task automatic test_impulse_to_hot();
    write_reg(RegRateThresholdImp, 16'd500);
    write_reg(RegRateThresholdMax, 16'd200);
    write_reg(RegRateThresholdMin, 16'd10);
    write_reg(RegAmpThreshold, 16'd4095);
    write_reg(RegMinObservations, 16'd2);
    write_reg(RegSamplesPerPeriod, 16'd64);
    send_sample(12'd1000);
    send_sample(12'd1020);
    write_reg(RegSamplesPerPeriod, 16'd0);
    send_sample(12'd1020);
  endtask

  // Fast rise after a fall stays idle; the second fast rise enters rising, then hot
  task automatic test_rising_blocked();
    send_sample(12'd500);
    send_sample(12'd800);
    send_sample(12'd1100);
    send_sample(12'd1400);
    send_sample(12'd1400);
  endtask

  // Upper data bits are dropped, unknown indexes ignored, limits above 100 kept
  task automatic test_register_masking();
    write_reg(RegAmpThreshold, 16'hF3E8);
    write_reg(RegProbLimitHigh, 16'hFFFF);
    write_reg(RegProbLimitLow, 16'h007F);
    write_reg(RegFirstUnused, 16'h0000);
    write_reg(RegLastUnused, 16'hFFFF);
    repeat (3) send_sample(12'd2000);
    send_sample(12'd0);
  endtask

  task automatic randomise_config();
    write_reg(RegAmpThreshold, with_junk(pick_value(1200, 3800, 0, 4095), LevelBits));
    write_reg(RegRateThresholdMax, with_junk(pick_value(40, 600, 0, 4095), LevelBits));
    write_reg(RegRateThresholdImp, with_junk(pick_value(300, 2500, 0, 4095), LevelBits));
    write_reg(RegRateThresholdMin, with_junk(pick_value(0, 80, 0, 4095), LevelBits));
    write_reg(RegMinObservations, with_junk(pick_value(0, 24, 0, 65535), CountBits));
    write_reg(RegProbLimitHigh, with_junk(pick_value(20, 95, 0, 127), LimitBits));
    write_reg(RegProbLimitLow, with_junk(pick_value(0, 45, 100, 127), LimitBits));
    write_reg(RegSamplesPerPeriod, with_junk(pick_value(0, 120, 1, 65535), CountBits));
    if ($urandom_range(0, 3) == 0)
      write_reg(RegFirstUnused + CfgIndexBits'($urandom_range(0, 7)),
                CfgDataBits'($urandom));
  endtask

  // Sensor-like bursts (quiet floor, ramps, impulses, plateaus) mixed with raw noise
  task automatic send_waveform(int count);
    shape_t shape;
    int     level;
    int     step;
    int     len;
    level = $urandom_range(0, 400);
    while (count > 0) begin
      shape = shape_t'($urandom_range(0, 5));
      len   = $urandom_range(2, 14);
      step  = $urandom_range(20, 700);
      if (shape == SHAPE_IMPULSE) level = $urandom_range(1200, MaxLevel);
      for (int k = 0; k < len && count > 0; k++) begin
        case (shape)
          SHAPE_QUIET:   level = $urandom_range(0, 300);
          SHAPE_RAMP:    level = level + step;
          SHAPE_IMPULSE: level = level + $urandom_range(0, 30);
          SHAPE_PLATEAU: level = $urandom_range(3000, MaxLevel);
          SHAPE_NOISE:   level = $urandom_range(0, MaxLevel);
          default:       level = $urandom_range(0, 1) ? MaxLevel : 0;
        endcase
        if (level > MaxLevel) level = MaxLevel;
        send_sample(level[LevelBits-1:0]);
        count--;
      end
    end
  endtask

  // Three idling phases, each under several register settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      settle_block();
      case (phase)
        0: begin
          send_idle_pct = 12;
          take_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          take_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      repeat (4) begin
        randomise_config();
        send_waveform(100);
      end
    end
  endtask

  // Hold hot with a full-scale period, which never expires it,
  // then release it with a zero period
  task automatic test_hot_hold();
    write_reg(RegAmpThreshold, 16'd0);
    write_reg(RegMinObservations, 16'd0);
    write_reg(RegProbLimitHigh, 16'd0);
    write_reg(RegProbLimitLow, 16'd0);
    write_reg(RegSamplesPerPeriod, 16'd65535);
    repeat (HotHoldItems) send_sample($urandom_range(1, MaxLevel));
    write_reg(RegSamplesPerPeriod, 16'd0);
    send_sample(12'd1);
    send_sample(12'd0);
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_thresholds();
    test_amplitude_to_hot();
    test_impulse_to_hot();
    test_rising_blocked();
    test_register_masking();
    test_random_traffic();
    test_hot_hold();

    // Drain, then allow the pipeline latency for any stray result
    settle_block();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
